// ----- src/kcg_pkg.sv -----
package kcg_pkg;

  localparam int MAX_SET    = 64;
  localparam int MAX_SUBSET = 8;

  localparam int IDX_W  = $clog2(MAX_SET);     // zero-based item index
  localparam int SET_W  = IDX_W + 1;           // set size / item number 1..MAX_SET
  localparam int SUB_W  = 4;                   // subset size register
  localparam int POS_W  = $clog2(MAX_SUBSET);  // position within a subset
  localparam int LIM_W  = SET_W + 1;           // e + position
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SET_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = CFG_IDX_W'(1);

  localparam logic [SET_W-1:0] SET_SIZE_RST    = SET_W'(2);
  localparam logic [SUB_W-1:0] SUBSET_SIZE_RST = SUB_W'(2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EMIT = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_FILL = 5'b01000,
    ST_EXH  = 5'b10000
  } seq_state_t;

  // sizes and control from the register block to the sequencer
  typedef struct packed {
    logic [SET_W-1:0] set_size;
    logic [SUB_W-1:0] subset_size;
    logic             invalid;
    logic             reload;
  } size_cfg_t;

  // sequencer command to the index store
  typedef struct packed {
    logic             load_first;
    logic             we;
    logic [POS_W-1:0] addr;
    logic [IDX_W-1:0] wdata;
  } idx_cmd_t;

endpackage

// ----- src/kcg_req_if.sv -----
interface kcg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- src/kcg_res_if.sv -----
interface kcg_res_if import kcg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SET_W-1:0] element_value;
  logic [2:0]       element_position;
  logic             last_element;
  logic             final_combination;
  logic             exhausted;

  modport source (output valid, output element_value, output element_position,
                  output last_element, output final_combination, output exhausted,
                  input ready);
  modport sink   (input valid, input element_value, input element_position,
                  input last_element, input final_combination, input exhausted,
                  output ready);
endinterface

// ----- src/kcg_cfg_if.sv -----
interface kcg_cfg_if import kcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/k_combination_generator.sv -----
// Lexicographic k-combination generator. Each request on in_ch hands out the
// current k-element subset of items 1..n as k results on out_ch, one element
// per result in ascending order, with the last result flagged; every result
// of the final subset carries final_combination. A request with restart set
// first reloads the subset 0..k-1; so do reset and every write to register
// 0 or 1. Once the subsets run out, each request answers with one exhausted
// result until a restart or a register write; with invalid sizes (k of 0 or
// above 8, n above 64, or n below k) that holds until a write fixes them.
// Register 0 is set_size n, register 1 is subset_size k; other indexes are
// ignored. Write the registers only while no request is in flight; cfg_ch
// holds off writes until the sequencer is idle. Each request is accepted,
// then emits its elements in order (holding while out_ch stalls), then
// scans down the index store for a position to raise and fills the
// positions after it before the next request is taken; an exhausted answer
// skips the scan and fill. The pace is set by the single read/write port of
// the index store and the one shared incrementer that serves output, raise
// and fill. The last result waits in an output register while the next
// request is accepted. No clearing pass is needed after reset.
module k_combination_generator import kcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  kcg_req_if.sink     in_ch,
  kcg_res_if.source   out_ch,
  kcg_cfg_if.sink     cfg_ch
);

  logic [SET_W-1:0] set_size_r, set_size_nxt;
  logic [SUB_W-1:0] subset_size_r, subset_size_nxt;
  logic             cfg_wr;
  logic             cfg_hit;
  size_cfg_t        size_cfg;
  idx_cmd_t         idx_cmd;
  logic [IDX_W-1:0] idx_rd;

  // take writes only while the sequencer is idle, so a reload never lands
  // in the middle of a scan or fill
  assign cfg_ch.ready = in_ch.ready;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit      = cfg_wr &&
                        (cfg_ch.index == CFG_SET_SIZE || cfg_ch.index == CFG_SUBSET_SIZE);

  always_comb begin
    set_size_nxt    = set_size_r;
    subset_size_nxt = subset_size_r;
    if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_SET_SIZE:    set_size_nxt    = cfg_ch.data[SET_W-1:0];
        CFG_SUBSET_SIZE: subset_size_nxt = cfg_ch.data[SUB_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= SUBSET_SIZE_RST;
    end else begin
      set_size_r    <= set_size_nxt;
      subset_size_r <= subset_size_nxt;
    end
  end

  // flag sizes that leave no subset to hand out
  assign size_cfg.set_size    = set_size_r;
  assign size_cfg.subset_size = subset_size_r;
  assign size_cfg.invalid     = (subset_size_r == '0) ||
                                (subset_size_r > SUB_W'(MAX_SUBSET)) ||
                                (set_size_r > SET_W'(MAX_SET)) ||
                                (set_size_r < SET_W'(subset_size_r));
  // a write to register 0 or 1 reloads the first subset
  assign size_cfg.reload      = cfg_hit;

  kcg_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (size_cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .idx_cmd (idx_cmd),
    .idx_rd  (idx_rd)
  );

  kcg_idx_file u_idx_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (idx_cmd),
    .rd_data (idx_rd)
  );

endmodule

// ----- src/kcg_idx_file.sv -----
module kcg_idx_file import kcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  idx_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] idx_r [MAX_SUBSET];

  // reset and reload put position i at index i
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_first) begin
      for (int i = 0; i < MAX_SUBSET; i++) begin
        idx_r[i] <= IDX_W'(i);
      end
    end else if (cmd.we) begin
      idx_r[cmd.addr] <= cmd.wdata;
    end
  end

  assign rd_data = idx_r[cmd.addr];

endmodule

// ----- src/kcg_seq.sv -----
module kcg_seq import kcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  size_cfg_t        cfg,
  kcg_req_if.sink          in_ch,
  kcg_res_if.source        out_ch,
  output idx_cmd_t         idx_cmd,
  input  logic [IDX_W-1:0] idx_rd
);

  seq_state_t       state_r, state_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic             fin_r, fin_nxt;
  logic             done_r, done_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [SET_W-1:0] out_val_r, out_val_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_fin_r, out_fin_nxt;
  logic             out_exh_r, out_exh_nxt;

  logic             accept;
  logic             slot_free;
  logic [SET_W-1:0] e_w;
  logic [LIM_W-1:0] limit_w;
  logic             at_limit;
  logic             cur_is_last;
  logic [IDX_W-1:0] inc_op;
  logic [SET_W-1:0] inc_sum;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_vld_r || out_ch.ready;

  assign e_w         = cfg.set_size - SET_W'(cfg.subset_size);
  assign limit_w     = LIM_W'(e_w) + LIM_W'(cur_r);
  assign at_limit    = LIM_W'(idx_rd) >= limit_w;
  assign cur_is_last = SUB_W'(cur_r) == (cfg.subset_size - SUB_W'(1));

  // shared incrementer
  assign inc_op  = (state_r == ST_FILL) ? prev_r : idx_rd;
  assign inc_sum = SET_W'(inc_op) + SET_W'(1);

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    fin_nxt      = fin_r;
    done_nxt     = done_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_val_nxt  = out_val_r;
    out_pos_nxt  = out_pos_r;
    out_last_nxt = out_last_r;
    out_fin_nxt  = out_fin_r;
    out_exh_nxt  = out_exh_r;

    idx_cmd.load_first = cfg.reload;
    idx_cmd.we         = 1'b0;
    idx_cmd.addr       = cur_r;
    idx_cmd.wdata      = inc_sum[IDX_W-1:0];

    if (cfg.reload) begin
      done_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_cmd.load_first = cfg.reload || in_ch.restart;
          cur_nxt = '0;
          if ((!in_ch.restart && done_r) || cfg.invalid) begin
            done_nxt  = 1'b1;
            state_nxt = ST_EXH;
          end else begin
            done_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = inc_sum;
          out_pos_nxt  = cur_r;
          out_last_nxt = cur_is_last;
          out_exh_nxt  = 1'b0;
          if (cur_r == '0) begin
            fin_nxt     = SET_W'(idx_rd) == e_w;
            out_fin_nxt = SET_W'(idx_rd) == e_w;
          end else begin
            out_fin_nxt = fin_r;
          end
          if (cur_is_last) begin
            state_nxt = ST_SCAN;
          end else begin
            cur_nxt = cur_r + POS_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (!at_limit) begin
          idx_cmd.we = 1'b1;
          prev_nxt   = inc_sum[IDX_W-1:0];
          if (cur_is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = cur_r + POS_W'(1);
            state_nxt = ST_FILL;
          end
        end else if (cur_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt = cur_r - POS_W'(1);
        end
      end
      ST_FILL: begin
        idx_cmd.we = 1'b1;
        prev_nxt   = inc_sum[IDX_W-1:0];
        if (cur_is_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt = cur_r + POS_W'(1);
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = '0;
          out_pos_nxt  = '0;
          out_last_nxt = 1'b1;
          out_fin_nxt  = 1'b0;
          out_exh_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= '0;
      done_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      done_r    <= done_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    fin_r      <= fin_nxt;
    out_val_r  <= out_val_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_fin_r  <= out_fin_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_vld_r;
  assign out_ch.element_value     = out_val_r;
  assign out_ch.element_position  = out_pos_r;
  assign out_ch.last_element      = out_last_r;
  assign out_ch.final_combination = out_fin_r;
  assign out_ch.exhausted         = out_exh_r;

  a_emit_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (SUB_W'(cur_r) < cfg.subset_size))
    else $error("emit cursor beyond subset size");

  a_exhausted_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_exh_r) |-> (out_last_r && out_val_r == '0 && !out_fin_r))
    else $error("malformed exhausted result");

  a_fill_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_nxt == ST_FILL) |-> (state_r == ST_SCAN || state_r == ST_FILL))
    else $error("fill entered without a scan");

endmodule

// ----- bench/k_combination_generator_tb.sv -----
`timescale 1ns / 1ps

// Stand-alone bench for the lexicographic k-combination generator.
// A request driver and a result monitor run as clocked processes; the main
// initial block only programs the sizes and queues up requests phase by phase.
module k_combination_generator_tb import kcg_pkg::*; ();

  // Out-of-range register indexes: writes to these must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Settling wait after the last result, for the scan and fill to run out.
  localparam int SETTLE_CYCLES = 32;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES   = 250;
  // Requests in the directed part plus the random part.
  localparam int REQUEST_GOAL  = 450;

  typedef struct packed {
    logic [SET_W-1:0] elem_value;
    logic [2:0]       elem_pos;
    logic             last_elem;
    logic             final_comb;
    logic             exhausted;
  } element_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kcg_req_if in_ch ();
  kcg_res_if out_ch ();
  kcg_cfg_if cfg_ch ();

  k_combination_generator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Generator shadow: sizes, index array and the exhausted flag, updated at the
  // edge where a request or a register write is accepted.
  // ---------------------------------------------------------------------------
  logic [SET_W-1:0] gen_set_size;
  logic [SUB_W-1:0] gen_subset_size;
  logic [IDX_W-1:0] gen_idx [MAX_SUBSET];
  logic             gen_done;

  element_t elements_due [$];   // elements still owed by the generator
  logic     restart_queue [$];  // requests waiting for the driver

  int  reqs_queued   = 0;
  int  reqs_accepted = 0;
  int  mismatches    = 0;
  bit  gaps_on       = 1'b1;    // random idling on both channels

  function automatic bit sizes_bad();
    int n;
    int k;
    n = int'(gen_set_size);
    k = int'(gen_subset_size);
    return k == 0 || k > MAX_SUBSET || n > MAX_SET || n < k;
  endfunction

  function automatic void load_first_subset();
    for (int i = 0; i < MAX_SUBSET; i++) begin
      gen_idx[i] = IDX_W'(i);
    end
    gen_done = sizes_bad();
  endfunction

  // Raise the rightmost position that still has headroom, then pack the
  // positions after it right behind it. No headroom anywhere: exhausted.
  function automatic void step_to_next_subset();
    int k;
    int e;
    int p;
    k = int'(gen_subset_size);
    e = int'(gen_set_size) - k;
    p = k;
    while (p > 0 && int'(gen_idx[p-1]) >= e + p - 1) begin
      p--;
    end
    if (p == 0) begin
      gen_done = 1'b1;
      return;
    end
    p--;
    gen_idx[p] = gen_idx[p] + 1'b1;
    for (int j = p + 1; j < k; j++) begin
      gen_idx[j] = gen_idx[j-1] + 1'b1;
    end
  endfunction

  function automatic void reset_generator();
    gen_set_size    = SET_SIZE_RST;
    gen_subset_size = SUBSET_SIZE_RST;
    load_first_subset();
  endfunction

  // A write to a known register reloads the first subset; others do nothing.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SET_SIZE: begin
        gen_set_size = val[SET_W-1:0];
      end
      CFG_SUBSET_SIZE: begin
        gen_subset_size = val[SUB_W-1:0];
      end
      default: begin
        return;
      end
    endcase
    load_first_subset();
  endfunction

  // Queue the elements one request produces, then advance the sequence.
  function automatic void serve_request(input logic restart);
    element_t el;
    int       k;
    logic     fin;
    if (restart) begin
      load_first_subset();
    end
    if (gen_done || sizes_bad()) begin
      gen_done      = 1'b1;
      el.elem_value = '0;
      el.elem_pos   = '0;
      el.last_elem  = 1'b1;
      el.final_comb = 1'b0;
      el.exhausted  = 1'b1;
      elements_due.push_back(el);
      return;
    end
    k   = int'(gen_subset_size);
    fin = (int'(gen_idx[0]) == int'(gen_set_size) - k);
    for (int i = 0; i < k; i++) begin
      el.elem_value = SET_W'(gen_idx[i]) + 1'b1;
      el.elem_pos   = 3'(i);
      el.last_elem  = (i == k - 1);
      el.final_comb = fin;
      el.exhausted  = 1'b0;
      elements_due.push_back(el);
    end
    step_to_next_subset();
  endfunction

  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: present the next queued request, hold it until taken, and
  // insert random idle bursts only between requests.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'b0;
      send_gap = 0;
    end else begin
      // Predict at the accepting edge, using the request as it stood there.
      if (in_ch.valid && in_ch.ready) begin
        serve_request(in_ch.restart);
        reqs_accepted++;
      end
      // Only touch the channel once the current request is gone.
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_ch.valid <= 1'b0;
        end else if (restart_queue.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.restart <= restart_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once, while plenty of requests are still waiting, stop
  // taking results long enough for the generator to back up into its input.
  // ---------------------------------------------------------------------------
  logic sink_hold = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      sink_hold <= (hold_left != 0);
    end else if (!hold_done && reqs_accepted >= 40 && restart_queue.size() >= 10) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      sink_hold <= 1'b1;
    end else begin
      sink_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every accepted element with the oldest one owed,
  // and stall the result channel in random bursts.
  // ---------------------------------------------------------------------------
  int sink_gap = 0;

  always @(posedge clk) begin
    element_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (elements_due.size() == 0) begin
          $error("unexpected element: value %0d position %0d exhausted %0d",
                 out_ch.element_value, out_ch.element_position, out_ch.exhausted);
          mismatches++;
        end else begin
          want = elements_due.pop_front();
          check_field("element_value", want.elem_value, out_ch.element_value);
          check_field("element_position", want.elem_pos, out_ch.element_position);
          check_field("last_element", want.last_elem, out_ch.last_element);
          check_field("final_combination", want.final_comb, out_ch.final_combination);
          check_field("exhausted", want.exhausted, out_ch.exhausted);
        end
      end
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel counts as progress.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers, all called from the main initial block at a rising edge.
  // ---------------------------------------------------------------------------

  // Wait for every request to be served and its elements delivered, then let
  // the scan/fill of the last request run out before touching registers.
  task automatic wait_quiet();
    while (reqs_accepted != reqs_queued || elements_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write until it is taken; the caller drops valid after a series.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    apply_reg_write(idx, val);
  endtask

  task automatic set_sizes(input int n, input int k);
    wait_quiet();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_SET_SIZE, CFG_DATA_W'(n));
      write_reg(CFG_SUBSET_SIZE, CFG_DATA_W'(k));
    end else begin
      write_reg(CFG_SUBSET_SIZE, CFG_DATA_W'(k));
      write_reg(CFG_SET_SIZE, CFG_DATA_W'(n));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_spare(input logic [CFG_IDX_W-1:0] idx);
    wait_quiet();
    write_reg(idx, CFG_DATA_W'($urandom_range(0, 127)));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_request(input logic restart);
    restart_queue.push_back(restart);
    reqs_queued++;
  endtask

  task automatic queue_random(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      queue_request($urandom_range(0, 99) < restart_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int k;
    int pick;

    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_SET_SIZE;
    cfg_ch.data   = '0;
    reset_generator();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes (2 of 2): single subset, then exhausted, restart, exhausted.
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b1);
    queue_request(1'b0);

    // Writes to unused indexes must neither change sizes nor reload.
    set_sizes(4, 2);
    queue_request(1'b0);
    write_spare(CFG_SPARE_A);
    queue_request(1'b0);
    write_spare(CFG_SPARE_B);
    queue_request(1'b0);
    // Rewriting the same size still reloads the first subset.
    set_sizes(4, 2);
    queue_request(1'b0);

    // Invalid sizes: set smaller than subset, zero subset, oversize subset,
    // oversize set.
    set_sizes(3, 4);
    queue_request(1'b0);
    queue_request(1'b1);
    set_sizes(5, 0);
    queue_request(1'b0);
    set_sizes(20, 9);
    queue_request(1'b0);
    set_sizes(127, 15);
    queue_request(1'b1);
    set_sizes(65, 2);
    queue_request(1'b0);

    // Largest sizes: full-width subset of the full set.
    set_sizes(64, 8);
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b1);

    // Subset equals set: the first subset is also the final one.
    set_sizes(8, 8);
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b1);

    // Smallest sizes.
    set_sizes(1, 1);
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b1);

    // Short walk with carries across positions.
    set_sizes(6, 3);
    queue_random(4, 0);

    // Walk the whole 64-item set one at a time so every item number shows up;
    // this deep queue also feeds the long receiver hold-off.
    set_sizes(64, 1);
    queue_random(70, 0);

    // Random phases: mostly small sets that run out, some large, some junk.
    while (reqs_queued < REQUEST_GOAL - 30) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        n = $urandom_range(0, 127);
        k = $urandom_range(0, 15);
      end else if (pick < 25) begin
        k = $urandom_range(1, MAX_SUBSET);
        n = $urandom_range(k, MAX_SET);
      end else begin
        k = $urandom_range(1, MAX_SUBSET);
        n = k + $urandom_range(0, 5);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_spare($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B);
      end
      set_sizes(n, k);
      queue_random($urandom_range(8, 40), 5);
    end

    // Closing stretch with both sides running flat out.
    wait_quiet();
    gaps_on = 1'b0;
    set_sizes(7, 3);
    queue_random(30, 3);

    while (reqs_accepted != reqs_queued || elements_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && elements_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
